[sv/wsfd_pkg.sv]
// ----------------------------------------------------------------------------
// wsfd_pkg
// types and constants shared by the frame deframer modules
// ----------------------------------------------------------------------------
`default_nettype none
package wsfd_pkg;

  typedef enum logic [2:0] {
    PH_BASIC = 3'd0,
    PH_EXT   = 3'd1,
    PH_PAY   = 3'd2,
    PH_RECOV = 3'd3,
    PH_FATAL = 3'd4
  } phase_t;

  localparam logic [1:0] KIND_HDR = 2'd0;
  localparam logic [1:0] KIND_PAY = 2'd1;
  localparam logic [1:0] KIND_ERR = 2'd2;

  localparam logic [2:0] ERR_NONE     = 3'd0;
  localparam logic [2:0] ERR_RSV_BIT  = 3'd1;
  localparam logic [2:0] ERR_RSV_OP   = 3'd2;
  localparam logic [2:0] ERR_CTRL_BIG = 3'd3;
  localparam logic [2:0] ERR_FRAG_CTL = 3'd4;
  localparam logic [2:0] ERR_NONMIN   = 3'd5;
  localparam logic [2:0] ERR_LIMIT    = 3'd6;
  localparam logic [2:0] ERR_DEGRADED = 3'd7;

  localparam logic [7:0] CLOSE_BYTE = 8'h88;
  localparam logic [6:0] LEN_16     = 7'd126;
  localparam logic [6:0] LEN_64     = 7'd127;
  localparam logic [3:0] OP_BINARY  = 4'h2;
  localparam logic [3:0] OP_CLOSE   = 4'h8;
  localparam logic [3:0] OP_PONG    = 4'hA;
  localparam logic [31:0] LIMIT_RESET = 32'd1048576;

  typedef struct packed {
    logic [1:0]  kind;
    logic [7:0]  data_byte;
    logic [3:0]  opcode;
    logic        fin_bit;
    logic        was_masked;
    logic [31:0] payload_length;
    logic        frame_end;
    logic [2:0]  error_code;
    logic        fatal;
  } result_t;

endpackage
`default_nettype wire

[sv/wsfd_if.sv]
// ----------------------------------------------------------------------------
// wsfd byte and result channel interfaces
// valid/ready channels for input bytes and results
// ----------------------------------------------------------------------------
`default_nettype none
interface wsfd_byte_if;
  logic       valid;
  logic       ready;
  logic [7:0] in_byte;
  modport source (output valid, output in_byte, input ready);
  modport sink (input valid, input in_byte, output ready);
endinterface

interface wsfd_res_if;
  logic        valid;
  logic        ready;
  logic [1:0]  kind;
  logic [7:0]  data_byte;
  logic [3:0]  opcode;
  logic        fin_bit;
  logic        was_masked;
  logic [31:0] payload_length;
  logic        frame_end;
  logic [2:0]  error_code;
  logic        fatal;
  modport source (output valid, output kind, output data_byte, output opcode,
                  output fin_bit, output was_masked, output payload_length,
                  output frame_end, output error_code, output fatal, input ready);
  modport sink (input valid, input kind, input data_byte, input opcode,
                input fin_bit, input was_masked, input payload_length,
                input frame_end, input error_code, input fatal, output ready);
endinterface
`default_nettype wire

[sv/ws_frame_deframer_unit.sv]
// result path: a result enters the result queue when its byte is taken
// throughput: one byte per cycle while the result channel keeps up; the
//   two-entry result queue decouples the parser from the result channel
// reset: synchronous active-low rst_n returns to the basic header phase,
//   clears the degraded mark and the queue, and loads the limit 1048576
// ----------------------------------------------------------------------------
// ws_frame_deframer_unit
// frame deframer top level: parser front, result queue back
// ----------------------------------------------------------------------------
`default_nettype none
module ws_frame_deframer_unit #(
  parameter int LENGTH_BITS = 32
) (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        cfg_we,
  input  wire logic [31:0] cfg_wdata,
  wsfd_byte_if.sink        in_ch,
  wsfd_res_if.source       out_ch
);

  logic [31:0] limit_r;
  logic        room;
  logic        res_valid;
  wsfd_pkg::result_t res;

  always_ff @(posedge clk) begin
    if (!rst_n) limit_r <= wsfd_pkg::LIMIT_RESET;
    else if (cfg_we) limit_r <= cfg_wdata;
  end

  assign in_ch.ready = room;

  wsfd_parser #(.LENGTH_BITS(LENGTH_BITS)) u_parser (
    .clk(clk), .rst_n(rst_n),
    .byte_valid(in_ch.valid && room),
    .byte_in(in_ch.in_byte),
    .limit(limit_r),
    .res(res),
    .res_valid(res_valid)
  );

  wsfd_queue u_queue (
    .clk(clk), .rst_n(rst_n),
    .push(res_valid),
    .push_data(res),
    .has_room(room),
    .res_ch(out_ch)
  );

endmodule
`default_nettype wire

[sv/wsfd_parser.sv]
// ----------------------------------------------------------------------------
// wsfd_parser
// front part: header collection, checks, payload unmasking, one byte a cycle
// ----------------------------------------------------------------------------
`default_nettype none
module wsfd_parser #(
  parameter int LENGTH_BITS = 32
) (
  input  wire logic                    clk,
  input  wire logic                    rst_n,
  input  wire logic                    byte_valid,
  input  wire logic [7:0]              byte_in,
  input  wire logic [31:0]             limit,
  output wsfd_pkg::result_t            res,
  output logic                         res_valid
);

  wsfd_pkg::phase_t phase_r, phase_nxt;
  logic [7:0]  b0_r, b0_nxt, b1_r, b1_nxt;
  logic [63:0] ext_r, ext_nxt;
  logic [7:0]  key_r [4];
  logic [3:0]  cnt_r, cnt_nxt;
  logic [63:0] left_r, left_nxt;
  logic [1:0]  kidx_r, kidx_nxt;
  logic        degr_r, degr_nxt;

  // header bytes of the current header (byte0 may come from this beat)
  logic [7:0]  h0, h1;
  logic [6:0]  s7;
  logic [3:0]  hlen;
  logic [63:0] ext_shift;
  logic [63:0] len64;
  logic [3:0]  op;
  logic        ctrl;
  logic [2:0]  bcode;
  logic        key_wr;
  logic [1:0]  key_sel;

  always_comb begin
    h0 = (phase_r == wsfd_pkg::PH_BASIC && cnt_r[0] == 1'b0) ? byte_in : b0_r;
    h1 = (phase_r == wsfd_pkg::PH_BASIC) ? byte_in : b1_r;
    s7 = h1[6:0];
    hlen = 4'd2 + (h1[7] ? 4'd4 : 4'd0) + ((s7 == wsfd_pkg::LEN_16) ? 4'd2 :
           (s7 == wsfd_pkg::LEN_64) ? 4'd8 : 4'd0);
    op = h0[3:0];
    ctrl = op >= wsfd_pkg::OP_CLOSE;
    if (s7 > 7'd125 && ctrl) bcode = wsfd_pkg::ERR_CTRL_BIG;
    else if (h0[6:4] != 3'd0) bcode = wsfd_pkg::ERR_RSV_BIT;
    else if ((op > wsfd_pkg::OP_BINARY && op < wsfd_pkg::OP_CLOSE) ||
             op > wsfd_pkg::OP_PONG) bcode = wsfd_pkg::ERR_RSV_OP;
    else if (ctrl && !h0[7]) bcode = wsfd_pkg::ERR_FRAG_CTL;
    else bcode = wsfd_pkg::ERR_NONE;
    ext_shift = {ext_r[55:0], byte_in};
  end

  always_comb begin
    logic [63:0] len;
    logic [2:0]  code;
    logic        do_finish;
    logic [3:0]  cnt1;
    logic        ext_byte;
    phase_nxt = phase_r;
    b0_nxt = b0_r;
    b1_nxt = b1_r;
    ext_nxt = ext_r;
    cnt_nxt = cnt_r;
    left_nxt = left_r;
    kidx_nxt = kidx_r;
    degr_nxt = degr_r;
    res = '0;
    res.opcode = h0[3:0];
    res.fin_bit = h0[7];
    res.was_masked = h1[7];
    res_valid = 1'b0;
    key_wr = 1'b0;
    key_sel = 2'd0;
    len = '0;
    code = wsfd_pkg::ERR_NONE;
    do_finish = 1'b0;
    cnt1 = cnt_r + 4'd1;
    ext_byte = 1'b0;
    len64 = '0;
    if (byte_valid) begin
      unique case (phase_r)
        wsfd_pkg::PH_BASIC: begin
          cnt_nxt = cnt1;
          if (cnt_r[0] == 1'b0) begin
            b0_nxt = byte_in;
          end else begin
            b1_nxt = byte_in;
            if (bcode != wsfd_pkg::ERR_NONE) code = bcode;
            else if (hlen > 4'd2) phase_nxt = wsfd_pkg::PH_EXT;
            else do_finish = 1'b1;
          end
        end
        wsfd_pkg::PH_EXT: begin
          cnt_nxt = cnt1;
          // extended length bytes first, then key bytes
          if (cnt1 <= hlen - (b1_r[7] ? 4'd4 : 4'd0)) begin
            ext_byte = 1'b1;
            ext_nxt = ext_shift;
          end else begin
            key_wr = 1'b1;
            key_sel = 2'(cnt_r - (hlen - 4'd4));
          end
          if (cnt1 == hlen) do_finish = 1'b1;
        end
        wsfd_pkg::PH_PAY: begin
          res_valid = 1'b1;
          res.kind = wsfd_pkg::KIND_PAY;
          res.data_byte = b1_r[7] ? (byte_in ^ key_r[kidx_r]) : byte_in;
          kidx_nxt = kidx_r + 2'd1;
          left_nxt = left_r - 64'd1;
          if (left_r == 64'd1) begin
            res.frame_end = 1'b1;
            degr_nxt = 1'b0;
            phase_nxt = wsfd_pkg::PH_BASIC;
            cnt_nxt = '0;
          end
        end
        wsfd_pkg::PH_RECOV: begin
          if (byte_in == wsfd_pkg::CLOSE_BYTE) begin
            b0_nxt = byte_in;
            cnt_nxt = 4'd1;
            phase_nxt = wsfd_pkg::PH_BASIC;
          end
        end
        default: begin
        end
      endcase
      if (do_finish) begin
        len64 = ext_byte ? ext_shift : ext_r;
        if (s7 == wsfd_pkg::LEN_16) begin
          len = {48'd0, len64[15:0]};
          if (len < 64'd126) code = wsfd_pkg::ERR_NONMIN;
        end else if (s7 == wsfd_pkg::LEN_64) begin
          len = len64;
          if (len <= 64'hFFFF) code = wsfd_pkg::ERR_NONMIN;
        end else begin
          len = {57'd0, s7};
        end
        if (code == wsfd_pkg::ERR_NONE &&
            ((len >> LENGTH_BITS) != 64'd0 || len > {32'd0, limit}))
          code = wsfd_pkg::ERR_LIMIT;
        if (code == wsfd_pkg::ERR_NONE) begin
          res_valid = 1'b1;
          res.kind = wsfd_pkg::KIND_HDR;
          res.payload_length = len[31:0];
          left_nxt = len;
          kidx_nxt = '0;
          cnt_nxt = '0;
          ext_nxt = '0;
          if (len == 64'd0) begin
            res.frame_end = 1'b1;
            degr_nxt = 1'b0;
            phase_nxt = wsfd_pkg::PH_BASIC;
          end else begin
            phase_nxt = wsfd_pkg::PH_PAY;
          end
        end
      end
      if (code != wsfd_pkg::ERR_NONE) begin
        res_valid = 1'b1;
        res.kind = wsfd_pkg::KIND_ERR;
        res.fatal = (code == wsfd_pkg::ERR_LIMIT) || degr_r;
        res.error_code = (code != wsfd_pkg::ERR_LIMIT && degr_r) ?
                         wsfd_pkg::ERR_DEGRADED : code;
        cnt_nxt = '0;
        left_nxt = '0;
        kidx_nxt = '0;
        ext_nxt = '0;
        if (res.fatal) phase_nxt = wsfd_pkg::PH_FATAL;
        else begin
          phase_nxt = wsfd_pkg::PH_RECOV;
          degr_nxt = 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r <= wsfd_pkg::PH_BASIC;
      cnt_r <= '0;
      left_r <= '0;
      kidx_r <= '0;
      degr_r <= 1'b0;
      ext_r <= '0;
    end else begin
      phase_r <= phase_nxt;
      cnt_r <= cnt_nxt;
      left_r <= left_nxt;
      kidx_r <= kidx_nxt;
      degr_r <= degr_nxt;
      ext_r <= ext_nxt;
    end
  end

  always_ff @(posedge clk) begin
    b0_r <= b0_nxt;
    b1_r <= b1_nxt;
    if (key_wr) key_r[key_sel] <= byte_in;
  end

endmodule
`default_nettype wire

[sv/wsfd_queue.sv]
// ----------------------------------------------------------------------------
// wsfd_queue
// back part: two-entry result queue driving the result channel
// ----------------------------------------------------------------------------
`default_nettype none
module wsfd_queue (
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire logic              push,
  input  wire wsfd_pkg::result_t push_data,
  output logic                   has_room,
  wsfd_res_if.source             res_ch
);

  wsfd_pkg::result_t mem_r [2];
  logic       wp_r, rp_r;
  logic [1:0] cnt_r, cnt_nxt;
  logic       pop;

  assign pop = res_ch.valid && res_ch.ready;
  assign has_room = (cnt_r != 2'd2) || pop;
  assign cnt_nxt = cnt_r + {1'b0, push} - {1'b0, pop};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r <= 1'b0;
      rp_r <= 1'b0;
      cnt_r <= '0;
    end else begin
      if (push) wp_r <= ~wp_r;
      if (pop) rp_r <= ~rp_r;
      cnt_r <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push) mem_r[wp_r] <= push_data;
  end

  wsfd_pkg::result_t head;
  assign head = mem_r[rp_r];
  assign res_ch.valid = cnt_r != 2'd0;
  assign res_ch.kind = head.kind;
  assign res_ch.data_byte = head.data_byte;
  assign res_ch.opcode = head.opcode;
  assign res_ch.fin_bit = head.fin_bit;
  assign res_ch.was_masked = head.was_masked;
  assign res_ch.payload_length = head.payload_length;
  assign res_ch.frame_end = head.frame_end;
  assign res_ch.error_code = head.error_code;
  assign res_ch.fatal = head.fatal;

endmodule
`default_nettype wire

[sv/wsfd_checker.sv]
// ----------------------------------------------------------------------------
// wsfd_checker
// port-level checks of the deframer result channel
// ----------------------------------------------------------------------------
`default_nettype none
module wsfd_checker (
  input wire logic        clk,
  input wire logic        rst_n,
  input wire logic        out_valid,
  input wire logic        out_ready,
  input wire logic [1:0]  out_kind,
  input wire logic        out_frame_end,
  input wire logic [2:0]  out_error_code,
  input wire logic        out_fatal
);

  a_err_no_end: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_kind == wsfd_pkg::KIND_ERR |-> !out_frame_end)
    else $error("error beat marked frame end");

  a_err_code: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_kind != wsfd_pkg::KIND_ERR |->
      out_error_code == wsfd_pkg::ERR_NONE && !out_fatal)
    else $error("non-error beat carries error");

  a_limit_fatal: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_kind == wsfd_pkg::KIND_ERR &&
    (out_error_code == wsfd_pkg::ERR_LIMIT || out_error_code == wsfd_pkg::ERR_DEGRADED)
    |-> out_fatal)
    else $error("limit error not fatal");

  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_kind))
    else $error("stalled beat changed");

endmodule

bind ws_frame_deframer_unit wsfd_checker u_checker (
  .clk(clk), .rst_n(rst_n),
  .out_valid(out_ch.valid), .out_ready(out_ch.ready),
  .out_kind(out_ch.kind), .out_frame_end(out_ch.frame_end),
  .out_error_code(out_ch.error_code), .out_fatal(out_ch.fatal)
);
`default_nettype wire
